// ===== hw/rtl/ibfd_pkg.sv =====
// ----------------------------------------------------------------------------
// ibfd_pkg
// Shared types and constants of the receiver frame channel decoder.
// ----------------------------------------------------------------------------
package ibfd_pkg;

  localparam int unsigned CHANNEL_COUNT = 14;
  localparam int unsigned POS_W         = 6;
  localparam int unsigned IDX_W         = 4;
  localparam int unsigned CFG_IDX_W     = 8;

  localparam logic [7:0] HDR_FIRST_RESET  = 8'h20;
  localparam logic [7:0] HDR_SECOND_RESET = 8'h40;

  localparam logic [CFG_IDX_W-1:0] REG_HDR_FIRST  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HDR_SECOND = CFG_IDX_W'(1);

  localparam logic [POS_W-1:0] POS_SECOND_HDR = POS_W'(1);
  localparam logic [POS_W-1:0] POS_FIRST_CHAN = POS_W'(2);
  localparam logic [IDX_W-1:0] LAST_IDX       = IDX_W'(CHANNEL_COUNT - 1);

  typedef struct packed {
    logic [7:0] first_byte;
    logic [7:0] second_byte;
  } ibfd_hdr_t;

  typedef struct packed {
    logic [15:0]      frame_sum;
    logic             last_channel;
    logic [15:0]      channel_value;
    logic [IDX_W-1:0] channel_index;
  } ibfd_result_t;

endpackage

// ===== hw/rtl/ibfd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// ibfd_cfg_regs
// Header byte registers written through the configuration channel.
// ----------------------------------------------------------------------------
module ibfd_cfg_regs
  import ibfd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [7:0]           wr_data,
  output ibfd_hdr_t            hdr
);

  ibfd_hdr_t hdr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r.first_byte  <= HDR_FIRST_RESET;
      hdr_r.second_byte <= HDR_SECOND_RESET;
    end else if (wr_en) begin
      if (wr_index == REG_HDR_FIRST) begin
        hdr_r.first_byte <= wr_data;
      end
      if (wr_index == REG_HDR_SECOND) begin
        hdr_r.second_byte <= wr_data;
      end
    end
  end

  assign hdr = hdr_r;

endmodule

// ===== hw/rtl/ibfd_parser.sv =====
// ----------------------------------------------------------------------------
// ibfd_parser
// Frame position tracking, header check, channel word assembly and byte sum.
// ----------------------------------------------------------------------------
module ibfd_parser
  import ibfd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         item_en,
  input  logic [7:0]   rx_byte,
  input  logic         frame_start,
  input  ibfd_hdr_t    hdr,
  output logic         res_valid,
  output ibfd_result_t res
);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             active_r, active_nxt;
  logic [7:0]       low_r, low_nxt;
  logic [15:0]      sum_r, sum_nxt;

  logic [15:0]      sum_add;
  logic [POS_W-1:0] pos_off;
  logic [IDX_W-1:0] idx;
  logic             is_last;

  assign sum_add = sum_r + {8'd0, rx_byte};
  assign pos_off = pos_r - POS_FIRST_CHAN;
  assign idx     = pos_off[IDX_W:1];
  assign is_last = (idx >= LAST_IDX);

  always_comb begin
    pos_nxt    = pos_r;
    active_nxt = active_r;
    low_nxt    = low_r;
    sum_nxt    = sum_r;
    res_valid  = 1'b0;
    res.channel_index = idx;
    res.channel_value = {rx_byte, low_r};
    res.last_channel  = is_last;
    res.frame_sum     = is_last ? sum_add : 16'd0;
    if (item_en) begin
      if (frame_start) begin
        low_nxt    = 8'd0;
        active_nxt = (rx_byte == hdr.first_byte);
        pos_nxt    = active_nxt ? POS_SECOND_HDR : '0;
        sum_nxt    = active_nxt ? {8'd0, rx_byte} : 16'd0;
      end else if (active_r) begin
        if (pos_r == POS_SECOND_HDR) begin
          if (rx_byte == hdr.second_byte) begin
            sum_nxt = sum_add;
            pos_nxt = POS_FIRST_CHAN;
          end else begin
            active_nxt = 1'b0;
          end
        end else if (!pos_r[0]) begin
          sum_nxt = sum_add;
          low_nxt = rx_byte;
          pos_nxt = pos_r + POS_W'(1);
        end else begin
          sum_nxt   = sum_add;
          res_valid = 1'b1;
          if (is_last) begin
            active_nxt = 1'b0;
          end else begin
            pos_nxt = pos_r + POS_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      active_r <= 1'b0;
      low_r    <= 8'd0;
      sum_r    <= 16'd0;
    end else begin
      pos_r    <= pos_nxt;
      active_r <= active_nxt;
      low_r    <= low_nxt;
      sum_r    <= sum_nxt;
    end
  end

endmodule

// ===== hw/rtl/ibfd_out_reg.sv =====
// ----------------------------------------------------------------------------
// ibfd_out_reg
// Result register holding one decoded channel until the sink takes it.
// ----------------------------------------------------------------------------
module ibfd_out_reg
  import ibfd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         load,
  input  ibfd_result_t load_data,
  output logic         can_load,
  output logic         out_valid,
  input  logic         out_ready,
  output ibfd_result_t out_data
);

  logic         valid_r;
  ibfd_result_t data_r;

  assign can_load = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_load) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load) begin
      data_r <= load_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ===== hw/rtl/ibus_frame_channel_decoder.sv =====
// ----------------------------------------------------------------------------
// ibus_frame_channel_decoder
// Decodes receiver frames byte by byte into indexed 16-bit channel words.
// ----------------------------------------------------------------------------
// The block takes one frame byte per cycle and answers with its item in the
// next cycle: every second channel byte produces a channel item in the result
// register, and a new byte is taken whenever that register is empty or being
// emptied in the same cycle. Frames whose first two bytes differ from the
// header registers are dropped until the next start byte, and the byte sum is
// reported with the last channel only.
module ibus_frame_channel_decoder
  import ibfd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [7:0] rx_byte
  input  logic                 in_tuser,   // [0] frame_start
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [39:0]          out_tdata,  // [3:0] channel_index, [19:4] channel_value,
                                           // [35:20] frame_sum, [39:36] zero
  output logic                 out_tlast,  // last_channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  ibfd_hdr_t    hdr;
  ibfd_result_t res, out_res;
  logic         res_valid;
  logic         can_load;
  logic         in_fire;

  assign cfg_ready = 1'b1;
  assign in_tready = can_load;
  assign in_fire   = in_tvalid && can_load;

  ibfd_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .hdr      (hdr)
  );

  ibfd_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_en     (in_fire),
    .rx_byte     (in_tdata),
    .frame_start (in_tuser),
    .hdr         (hdr),
    .res_valid   (res_valid),
    .res         (res)
  );

  ibfd_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_valid),
    .load_data (res),
    .can_load  (can_load),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_res)
  );

  assign out_tdata = {4'd0, out_res.frame_sum, out_res.channel_value, out_res.channel_index};
  assign out_tlast = out_res.last_channel;

endmodule

// ===== tb/ibus_frame_channel_decoder_tb.sv =====
// ----------------------------------------------------------------------------
// ibus_frame_channel_decoder_tb
// Self-checking bench for the receiver frame channel decoder.
// ----------------------------------------------------------------------------
// Frame bytes go in as a stream, and the bench decodes the same bytes with its
// own copy of the header registers and frame state. Each channel item that
// comes out is checked against the oldest predicted one. The run starts with
// directed frames and then sends random well-formed, truncated, misheaded and
// noise sequences. Both sides stall at random, and the header registers are
// rewritten between phases, the extremes among them.
// ----------------------------------------------------------------------------
module ibus_frame_channel_decoder_tb
  import ibfd_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(255);
  localparam int unsigned CYCLE_LIMIT = 600000;

  typedef struct {
    logic [7:0] rx_byte;
    logic       frame_start;
    bit         wait_drain;
  } frame_byte_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [7:0]           in_tdata = '0;
  logic                 in_tuser = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [39:0]          out_tdata;
  logic                 out_tlast;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data = '0;

  ibus_frame_channel_decoder dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ibfd_hdr_t    header = '{first_byte: HDR_FIRST_RESET, second_byte: HDR_SECOND_RESET};
  logic [5:0]   byte_pos = '0;
  bit           in_frame = 1'b0;
  logic [7:0]   low_byte = '0;
  logic [15:0]  byte_sum = '0;

  frame_byte_t  byte_queue[$];
  ibfd_result_t pending_channels[$];
  bit           idle_enable = 1'b1;
  int unsigned  send_gap = 0;
  int unsigned  stall_left = 0;
  int unsigned  mismatches = 0;
  int unsigned  bytes_sent = 0;
  int unsigned  channels_seen = 0;
  int unsigned  frames_seen = 0;
  int unsigned  cycles = 0;

  function automatic bit channel_from_byte(input logic [7:0] b, input logic start,
                                           output ibfd_result_t res);
    logic [5:0] idx;
    bit         last;
    res = '0;
    if (start) begin
      byte_pos = '0;
      low_byte = '0;
      byte_sum = '0;
      in_frame = (b == header.first_byte);
      if (in_frame) begin
        byte_sum = 16'(b);
        byte_pos = 6'(POS_SECOND_HDR);
      end
      return 1'b0;
    end
    if (!in_frame) return 1'b0;
    if (byte_pos == 6'(POS_SECOND_HDR)) begin
      if (b == header.second_byte) begin
        byte_sum = byte_sum + 16'(b);
        byte_pos = 6'(POS_FIRST_CHAN);
      end else begin
        in_frame = 1'b0;
      end
      return 1'b0;
    end
    byte_sum = byte_sum + 16'(b);
    if (!byte_pos[0]) begin
      low_byte = b;
      byte_pos = byte_pos + 6'd1;
      return 1'b0;
    end
    idx = (byte_pos - 6'd2) >> 1;
    last = (idx >= 6'(CHANNEL_COUNT - 1));
    res.channel_index = idx[IDX_W-1:0];
    res.channel_value = {b, low_byte};
    res.last_channel = last;
    res.frame_sum = last ? byte_sum : 16'd0;
    if (last) in_frame = 1'b0;
    else byte_pos = byte_pos + 6'd1;
    return 1'b1;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (!idle_enable) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void report_mismatch(input string what, input ibfd_result_t want,
                                          input logic [39:0] got_data, input logic got_last);
    mismatches++;
    if (mismatches <= 10)
      $display("ERROR %s: expected idx=%0d val=%h last=%b sum=%h, got tdata=%h tlast=%b",
               what, want.channel_index, want.channel_value, want.last_channel,
               want.frame_sum, got_data, got_last);
  endfunction

  always @(posedge clk) begin
    ibfd_result_t res;
    frame_byte_t  nxt;
    bit           fire;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      fire = in_tvalid && in_tready;
      if (fire) begin
        bytes_sent++;
        if (channel_from_byte(in_tdata, in_tuser, res)) pending_channels.push_back(res);
      end
      if (!in_tvalid || fire) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
          in_tdata <= 8'($urandom);
          in_tuser <= 1'($urandom);
        end else if (byte_queue.size() > 0 &&
                     !(byte_queue[0].wait_drain && pending_channels.size() > 0)) begin
          nxt = byte_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= nxt.rx_byte;
          in_tuser <= nxt.frame_start;
          send_gap = pick_gap();
        end else begin
          in_tvalid <= 1'b0;
          in_tdata <= 8'($urandom);
          in_tuser <= 1'($urandom);
        end
      end
    end
  end

  always @(posedge clk) begin
    ibfd_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        channels_seen++;
        if (out_tlast) frames_seen++;
        if (pending_channels.size() == 0) begin
          report_mismatch("unexpected channel item", '0, out_tdata, out_tlast);
        end else begin
          want = pending_channels.pop_front();
          if (out_tdata[3:0] !== want.channel_index ||
              out_tdata[19:4] !== want.channel_value ||
              out_tdata[35:20] !== want.frame_sum ||
              out_tdata[39:36] !== 4'd0 ||
              out_tlast !== want.last_channel)
            report_mismatch("channel item differs", want, out_tdata, out_tlast);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("ERROR: cycle limit reached with %0d items still expected",
               pending_channels.size());
      $display("ibus_frame_channel_decoder: mismatch");
      $finish;
    end
  end

  task automatic add_byte(input logic [7:0] b, input logic start, input bit hold = 1'b0);
    byte_queue.push_back('{rx_byte: b, frame_start: start, wait_drain: hold});
  endtask

  task automatic add_frame(input int unsigned body_len, input int unsigned tail_len);
    add_byte(header.first_byte, 1'b1);
    add_byte(header.second_byte, 1'b0);
    repeat (body_len) add_byte(8'($urandom), 1'b0);
    repeat (tail_len) add_byte(8'($urandom), 1'b0);
  endtask

  task automatic add_random_traffic(input int unsigned count, input bit with_holds);
    int unsigned start_len;
    int unsigned roll;
    logic [7:0]  b;
    start_len = byte_queue.size();
    while (byte_queue.size() - start_len < count) begin
      if (with_holds && $urandom_range(0, 9) == 0)
        add_byte(8'($urandom), 1'($urandom), 1'b1);
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        add_frame(2 * CHANNEL_COUNT, $urandom_range(0, 3));
      end else if (roll < 80) begin
        add_frame($urandom_range(0, 2 * CHANNEL_COUNT - 1), 0);
      end else if (roll < 90) begin
        b = 8'($urandom);
        if ($urandom_range(0, 1) == 0) begin
          if (b == header.first_byte) b = ~b;
          add_byte(b, 1'b1);
        end else begin
          if (b == header.second_byte) b = ~b;
          add_byte(header.first_byte, 1'b1);
          add_byte(b, 1'b0);
        end
        repeat ($urandom_range(0, 4)) add_byte(8'($urandom), 1'b0);
      end else begin
        repeat ($urandom_range(1, 6)) add_byte(8'($urandom), 1'($urandom_range(0, 3) == 0));
      end
    end
  endtask

  task automatic wait_for_drain();
    do @(negedge clk);
    while (byte_queue.size() > 0 || in_tvalid || pending_channels.size() > 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk);
    while (!(cfg_valid && cfg_ready));
    case (idx)
      REG_HDR_FIRST:  header.first_byte = val;
      REG_HDR_SECOND: header.second_byte = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    add_byte(8'hA5, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(~header.first_byte, 1'b1);
    add_byte(header.second_byte, 1'b0);
    add_byte(header.first_byte, 1'b1);
    add_byte(~header.second_byte, 1'b0);
    add_byte(8'h11, 1'b0);
    add_byte(header.first_byte, 1'b1);
    add_byte(header.second_byte, 1'b0);
    add_byte(8'h34, 1'b0);
    add_byte(8'h12, 1'b0);
    add_byte(header.first_byte, 1'b1);
    add_byte(header.second_byte, 1'b0);
    for (int i = 0; i < CHANNEL_COUNT; i++) begin
      add_byte((i % 2 == 0) ? 8'hFF : 8'h00, 1'b0);
      add_byte((i % 2 == 0) ? 8'hFF : 8'h00, 1'b0);
    end
    add_byte(8'hFF, 1'b0);
    add_byte(8'h00, 1'b0);
    add_random_traffic(240, 1'b0);
    wait_for_drain();

    write_reg(REG_HDR_FIRST, 8'h00);
    write_reg(REG_HDR_SECOND, 8'hFF);
    write_reg(REG_UNUSED, 8'($urandom));
    idle_enable = 1'b0;
    add_random_traffic(240, 1'b0);
    wait_for_drain();

    write_reg(REG_HDR_FIRST, 8'hFF);
    write_reg(REG_HDR_SECOND, 8'h00);
    idle_enable = 1'b1;
    add_byte(header.first_byte, 1'b1, 1'b1);
    add_random_traffic(240, 1'b1);
    wait_for_drain();

    write_reg(REG_HDR_FIRST, 8'($urandom));
    write_reg(REG_HDR_SECOND, 8'($urandom));
    add_random_traffic(240, 1'b1);
    wait_for_drain();

    write_reg(REG_HDR_FIRST, HDR_FIRST_RESET);
    write_reg(REG_HDR_SECOND, HDR_SECOND_RESET);
    add_random_traffic(240, 1'b0);
    wait_for_drain();

    repeat (20) @(negedge clk);
    if (pending_channels.size() > 0) begin
      mismatches++;
      $display("ERROR: %0d channel items never arrived", pending_channels.size());
    end
    $display("Sent %0d bytes under five header settings; checked %0d channel items",
             bytes_sent, channels_seen);
    $display("including %0d complete frames; %0d mismatches", frames_seen, mismatches);
    if (mismatches == 0) begin
      $display("ibus_frame_channel_decoder: match");
    end else begin
      $display("ibus_frame_channel_decoder: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/ibfd_pkg.sv
hw/rtl/ibfd_cfg_regs.sv
hw/rtl/ibfd_parser.sv
hw/rtl/ibfd_out_reg.sv
hw/rtl/ibus_frame_channel_decoder.sv
tb/ibus_frame_channel_decoder_tb.sv
